// ----- hdl/qdd_pkg.sv -----
// qdd_pkg: shared types, reset constants and the quadrature lookup for the
// detent decoder. No dependencies.
`timescale 1ns / 1ps

package qdd_pkg;

  localparam int PAUSE_W  = 20;
  localparam int FAST_W   = 7;
  localparam int CHANGE_W = 8;
  localparam int CFG_W    = 20;

  localparam logic [PAUSE_W-1:0] PAUSE_RESET   = 20'd30000;
  localparam logic [FAST_W-1:0]  FAST_RESET    = 7'd5;
  localparam logic [1:0]         PREV_AB_RESET = 2'b11;

  typedef enum logic {
    REG_PAUSE_LENGTH = 1'b0,
    REG_FAST_STEP    = 1'b1
  } qdd_reg_t;

  typedef struct packed {
    logic [PAUSE_W-1:0] pause_length;
    logic [FAST_W-1:0]  fast_step;
  } qdd_cfg_t;

  typedef struct packed {
    logic                       fire;
    logic signed [CHANGE_W-1:0] change;
  } qdd_result_t;

  // transition index is {prev_a, prev_b, cur_a, cur_b}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] val;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: val = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: val = 2'sd1;
      default: val = 2'sd0;
    endcase
    return val;
  endfunction

endpackage

// ----- hdl/qdd_item_if.sv -----
// qdd_item_if: input channel of the detent decoder, pin sample or tick beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface qdd_item_if;
  logic valid;
  logic ready;
  logic kind;
  logic pin_a;
  logic pin_b;

  modport source (output valid, output kind, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input kind, input pin_a, input pin_b, output ready);
endinterface

// ----- hdl/qdd_detent_if.sv -----
// qdd_detent_if: result channel of the detent decoder, one signed change per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface qdd_detent_if;
  logic             valid;
  logic             ready;
  logic signed [7:0] change;

  modport source (output valid, output change, input ready);
  modport sink   (input valid, input change, output ready);
endinterface

// ----- hdl/qdd_cfg_if.sv -----
// qdd_cfg_if: register write channel, index and data per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface qdd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/qdd_cfg_regs.sv -----
// qdd_cfg_regs: pause_length and fast_step registers behind the write channel.
// Depends on qdd_pkg and qdd_cfg_if.
`timescale 1ns / 1ps

module qdd_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  qdd_cfg_if.sink          cfg,
  output qdd_pkg::qdd_cfg_t regs
);
  import qdd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pause_length <= PAUSE_RESET;
      regs.fast_step    <= FAST_RESET;
    end else if (cfg.valid) begin
      case (qdd_reg_t'(cfg.index))
        REG_PAUSE_LENGTH: regs.pause_length <= cfg.data[PAUSE_W-1:0];
        REG_FAST_STEP:    regs.fast_step    <= cfg.data[FAST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/qdd_step.sv -----
// qdd_step: decoder state (last pin pair, step accumulator, elapsed counters)
// and the per-item update logic. Depends on qdd_pkg.
`timescale 1ns / 1ps

module qdd_step #(
  parameter int TIME_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 kind,
  input  logic                 pin_a,
  input  logic                 pin_b,
  input  qdd_pkg::qdd_cfg_t    regs,
  output qdd_pkg::qdd_result_t res
);
  import qdd_pkg::*;

  localparam int CMP_W = (TIME_BITS > PAUSE_W) ? TIME_BITS : PAUSE_W;

  logic [1:0]             prev_ab;
  logic signed [3:0]      step_accum;
  logic [TIME_BITS-1:0]   since_up;
  logic [TIME_BITS-1:0]   since_down;

  logic [1:0]             cur_ab;
  logic signed [1:0]      quad;
  logic signed [3:0]      accum_sum;
  logic                   hit_up;
  logic                   hit_down;
  logic                   fast_up;
  logic                   fast_down;
  logic [FAST_W-1:0]      mag;
  logic [TIME_BITS-1:0]   up_inc;
  logic [TIME_BITS-1:0]   down_inc;

  assign cur_ab    = {pin_a, pin_b};
  assign quad      = quad_step({prev_ab, cur_ab});
  assign accum_sum = step_accum + {{2{quad[1]}}, quad};
  assign hit_up    = !kind && (accum_sum > 4'sd3);
  assign hit_down  = !kind && (accum_sum < -4'sd3);

  assign fast_up   = CMP_W'(since_up) < CMP_W'(regs.pause_length);
  assign fast_down = CMP_W'(since_down) < CMP_W'(regs.pause_length);

  always_comb begin
    mag = FAST_W'(1);
    if ((hit_up && fast_up) || (hit_down && fast_down)) begin
      mag = regs.fast_step;
    end
    res.fire   = hit_up || hit_down;
    res.change = hit_up ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
  end

  // saturating elapsed counters
  assign up_inc   = (since_up == '1) ? since_up : since_up + TIME_BITS'(1);
  assign down_inc = (since_down == '1) ? since_down : since_down + TIME_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab    <= PREV_AB_RESET;
      step_accum <= 4'sd0;
      since_up   <= '0;
      since_down <= '0;
    end else if (take) begin
      if (kind) begin
        since_up   <= up_inc;
        since_down <= down_inc;
      end else begin
        prev_ab <= cur_ab;
        if (hit_up) begin
          step_accum <= 4'sd0;
          since_up   <= '0;
        end else if (hit_down) begin
          step_accum <= 4'sd0;
          since_down <= '0;
        end else begin
          step_accum <= accum_sum;
        end
      end
    end
  end

endmodule

// ----- hdl/quadrature_detent_decoder_accel.sv -----
// quadrature_detent_decoder_accel: top level, input register, step logic and
// result register. Depends on qdd_pkg, the qdd_*_if interfaces, qdd_cfg_regs, qdd_step.
//
//   channel  dir  beat payload          accepted when
//   item     in   kind, pin_a, pin_b    item.valid && item.ready
//   detent   out  change (signed 8)     detent.valid && detent.ready
//   cfg      in   index, data           cfg.valid && cfg.ready (always ready)
//
// one item per cycle sustained unless a held result stalls it (see below); an item
// beat is caught in the input register, its result in the result register (step logic)
// rst is synchronous: pin pair reads both high, accumulator and counters clear
// a held result stalls only items that produce a result; ticks and quiet samples
// keep flowing through while detent.ready is low
`timescale 1ns / 1ps

module quadrature_detent_decoder_accel #(
  parameter int TIME_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  qdd_item_if.sink    item,
  qdd_detent_if.source detent,
  qdd_cfg_if.sink     cfg
);
  import qdd_pkg::*;

  qdd_cfg_t    regs;
  qdd_result_t res;

  logic s1_valid;
  logic s1_kind;
  logic s1_pin_a;
  logic s1_pin_b;
  logic take;
  logic out_valid;
  logic signed [CHANGE_W-1:0] out_change;

  qdd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  qdd_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .kind  (s1_kind),
    .pin_a (s1_pin_a),
    .pin_b (s1_pin_b),
    .regs  (regs),
    .res   (res)
  );

  assign take       = s1_valid && (!out_valid || detent.ready || !res.fire);
  assign item.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind  <= item.kind;
      s1_pin_a <= item.pin_a;
      s1_pin_b <= item.pin_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res.fire) begin
      out_valid <= 1'b1;
    end else if (detent.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.fire) begin
      out_change <= res.change;
    end
  end

  assign detent.valid  = out_valid;
  assign detent.change = out_change;

endmodule

// ----- hdl/qdd_checker.sv -----
// qdd_checker: port-level assertions on the detent decoder, and the bind that
// attaches them to quadrature_detent_decoder_accel. Depends on nothing else.
`timescale 1ns / 1ps

module qdd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_change
);

  // a waiting result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // and keeps its value
  a_hold_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_change))
    else $error("result beat changed while stalled");

  // magnitude never exceeds 127
  a_change_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_change != 8'h80)
    else $error("change out of range");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind quadrature_detent_decoder_accel qdd_checker u_qdd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (detent.valid),
  .out_ready  (detent.ready),
  .out_change (detent.change)
);

// ----- test/tb_quadrature_detent_decoder_accel.sv -----
// tb_quadrature_detent_decoder_accel: self-checking bench for the detent decoder. It runs
// directed rotations, a register sweep, the elapsed-count threshold, a result stall and random
// traffic. Depends on qdd_pkg, qdd_item_if, qdd_detent_if, qdd_cfg_if and the top level.
`timescale 1ns / 1ps

module tb_quadrature_detent_decoder_accel;
  import qdd_pkg::*;

  localparam int TIME_BITS    = 20;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int THRESH_PAUSE = 40;
  localparam int DRAIN_CYCLES = 8;

  localparam logic KIND_PIN  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [19:0] PAUSE_DEFAULT = 20'd30000;
  localparam logic [6:0]  FAST_DEFAULT  = 7'd5;
  localparam logic [19:0] PAUSE_MAX     = 20'hFFFFF;

  logic clk = 1'b0;
  logic rst;

  qdd_item_if   item_ch ();
  qdd_detent_if detent_ch ();
  qdd_cfg_if    cfg_ch ();

  quadrature_detent_decoder_accel #(.TIME_BITS(TIME_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .detent (detent_ch),
    .cfg    (cfg_ch)
  );

  logic [19:0]          pause_length;
  logic [6:0]           fast_step;
  logic [1:0]           last_ab;
  int                   step_accum;
  logic [TIME_BITS-1:0] since_up;
  logic [TIME_BITS-1:0] since_down;

  logic signed [7:0] expected_changes [$];

  int mismatches   = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // position of an ab pair along one electrical cycle, counting up
  function automatic logic [1:0] phase_of(logic [1:0] ab);
    return {ab[0], ab[1] ^ ab[0]};
  endfunction

  function automatic logic [1:0] ab_of(logic [1:0] ph);
    return {ph[1] ^ ph[0], ph[1]};
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_inc(logic [TIME_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void reset_decoder();
    pause_length = PAUSE_DEFAULT;
    fast_step    = FAST_DEFAULT;
    last_ab      = 2'b11;
    step_accum   = 0;
    since_up     = '0;
    since_down   = '0;
  endfunction

  function automatic void decode_beat(logic kind, logic [1:0] ab);
    logic [1:0] turn;
    logic [6:0] mag;
    if (kind == KIND_TICK) begin
      since_up   = sat_inc(since_up);
      since_down = sat_inc(since_down);
      return;
    end
    turn    = phase_of(ab) - phase_of(last_ab);
    last_ab = ab;
    if (turn == 2'd1) step_accum++;
    else if (turn == 2'd3) step_accum--;
    if (step_accum > 3) begin
      mag = (since_up < pause_length) ? fast_step : 7'd1;
      expected_changes.push_back($signed({1'b0, mag}));
      since_up   = '0;
      step_accum = 0;
    end else if (step_accum < -3) begin
      mag = (since_down < pause_length) ? fast_step : 7'd1;
      expected_changes.push_back(-$signed({1'b0, mag}));
      since_down = '0;
      step_accum = 0;
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : check_detent
    logic signed [7:0] want;
    if (!rst && detent_ch.valid && detent_ch.ready) begin
      if (expected_changes.size() == 0) begin
        report_mismatch($sformatf("detent beat with none expected, change %0d",
                                  detent_ch.change));
      end else begin
        want = expected_changes.pop_front();
        if (detent_ch.change !== want)
          report_mismatch($sformatf("change %0d, expected %0d", detent_ch.change, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** quadrature_detent_decoder_accel: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      detent_ch.ready = 1'b0;
      rx_hold_left--;
    end else begin
      detent_ch.ready = ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  task automatic send_item(logic kind, logic a, logic b);
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.kind  = kind;
    item_ch.pin_a = a;
    item_ch.pin_b = b;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    decode_beat(kind, {a, b});
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  task automatic turn_one(bit up);
    logic [1:0] ab;
    ab = ab_of(phase_of(last_ab) + (up ? 2'd1 : 2'd3));
    send_item(KIND_PIN, ab[1], ab[0]);
  endtask

  task automatic turn_detent(bit up);
    repeat (4) turn_one(up);
  endtask

  task automatic write_reg(qdd_reg_t which, logic [19:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = which;
    cfg_ch.data  = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (which == REG_PAUSE_LENGTH) pause_length = value;
    else fast_step = value[6:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // wait for every expected detent, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (expected_changes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(KIND_TICK, 1'b0, 1'b0);
    send_item(KIND_TICK, 1'b0, 1'b1);
    send_item(KIND_TICK, 1'b1, 1'b0);
    send_item(KIND_TICK, 1'b1, 1'b1);
    turn_detent(1'b1);
    turn_detent(1'b0);
    // both pins change at once, twice
    send_item(KIND_PIN, 1'b0, 1'b0);
    send_item(KIND_PIN, 1'b1, 1'b1);
    turn_one(1'b1);
    turn_one(1'b0);
    turn_one(1'b0);
    turn_one(1'b1);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(REG_PAUSE_LENGTH, 20'd0);
    turn_detent(1'b1);
    turn_detent(1'b0);
    settle();
    write_reg(REG_PAUSE_LENGTH, PAUSE_MAX);
    write_reg(REG_FAST_STEP, 20'd127);
    turn_detent(1'b1);
    turn_detent(1'b0);
    settle();
    // only the low seven bits land, giving a zero step
    write_reg(REG_FAST_STEP, 20'hFFF80);
    turn_detent(1'b1);
  endtask

  task automatic test_elapsed_threshold();
    settle();
    write_reg(REG_PAUSE_LENGTH, 20'(THRESH_PAUSE));
    write_reg(REG_FAST_STEP, 20'd9);
    turn_detent(1'b1);
    turn_detent(1'b0);
    // one tick short of the pause, then well past it
    repeat (THRESH_PAUSE - 1) send_tick();
    turn_detent(1'b1);
    repeat (THRESH_PAUSE) send_tick();
    turn_detent(1'b0);
    // exactly at the pause
    turn_detent(1'b1);
  endtask

  task automatic test_result_backpressure();
    settle();
    write_reg(REG_PAUSE_LENGTH, 20'd50);
    write_reg(REG_FAST_STEP, 20'd3);
    rx_hold_left = 300;
    repeat (12) begin
      turn_detent(1'b1);
      repeat ($urandom_range(6, 0)) send_tick();
    end
    repeat (3) turn_detent(1'b0);
  endtask

  task automatic test_random_rotation(int tx_pct, int rx_pct, int n_items);
    int         sent;
    int         pick;
    int         burst;
    bit         up;
    logic [1:0] ab;
    settle();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if ($urandom_range(3, 0) == 0)
      write_reg(REG_PAUSE_LENGTH, 20'($urandom_range(20'hFFFFF, 0)));
    else write_reg(REG_PAUSE_LENGTH, 20'($urandom_range(200, 0)));
    write_reg(REG_FAST_STEP, 20'($urandom_range(127, 1)));
    sent = 0;
    up   = 1'($urandom_range(1, 0));
    while (sent < n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < 10) up = !up;
      if (pick < 65) begin
        turn_one(up);
        sent++;
      end else if (pick < 77) begin
        burst = $urandom_range(12, 1);
        repeat (burst) send_tick();
        sent += burst;
      end else if (pick < 85) begin
        send_item(KIND_PIN, last_ab[1], last_ab[0]);
        sent++;
      end else if (pick < 92) begin
        ab = ~last_ab;
        send_item(KIND_PIN, ab[1], ab[0]);
        sent++;
      end else begin
        send_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                  1'($urandom_range(1, 0)));
        sent++;
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.kind    = KIND_PIN;
    item_ch.pin_a   = 1'b0;
    item_ch.pin_b   = 1'b0;
    detent_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_PAUSE_LENGTH;
    cfg_ch.data     = '0;
    reset_decoder();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_register_extremes();
    test_elapsed_threshold();
    test_result_backpressure();
    test_random_rotation(13, 77, 130);
    test_random_rotation(77, 13, 130);
    test_random_rotation(0, 0, 130);
    settle();

    if (mismatches == 0) begin
      $display("** quadrature_detent_decoder_accel: PASSED **");
    end else begin
      $display("** quadrature_detent_decoder_accel: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/qdd_pkg.sv
hdl/qdd_item_if.sv
hdl/qdd_detent_if.sv
hdl/qdd_cfg_if.sv
hdl/qdd_cfg_regs.sv
hdl/qdd_step.sv
hdl/quadrature_detent_decoder_accel.sv
hdl/qdd_checker.sv
test/tb_quadrature_detent_decoder_accel.sv
